/* rtl/pctrb_pkg.sv */
// Shared types and constants for the per-CPU trace ring buffer.
package pctrb_pkg;

   typedef enum logic [1:0] {
      REQ_RECORD     = 2'd0,
      REQ_READ_ALL   = 2'd1,
      REQ_READ_LOCAL = 2'd2,
      REQ_CLEAR      = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0] tick;
      logic [7:0]  event_code;
      logic [7:0]  task_num;
      logic [15:0] data;
   } record_type;

   localparam int REC_W      = $bits(record_type);
   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 80;
   localparam int RSP_USER_W = 1;
   localparam int INDEX_W    = 16;
   localparam int TOTAL_W    = 9;
   localparam int LOCAL_W    = 7;
   localparam int TOTAL_MAX  = 511;
   localparam int LOCAL_MAX  = 127;

endpackage

/* rtl/per_cpu_trace_ring_buffer_unit.sv */
// Per-CPU overwrite-oldest trace rings: record, local/global read and clear.
//
//   channel | direction | tdata (low bit up)                                | tuser
//   req_    | in        | cpu_id, tick_now, event_code, task_num, payload,  | req_type
//           |           | read_index, zero pad                              |
//   rsp_    | out       | out_tick, out_event, out_task, out_data,          | found
//           |           | total_count, local_count                          |
//
// For record, clear and local read, the accept cycle does the ring update or issues
// the RAM read, and the finish state then loads the result register.
// A global read walks the rings one CPU a cycle.
// Reset empties and marks stale every ring; the record RAM is not cleared.
// A stalled result holds the unit in its finish cycle; no new word is taken then.
module per_cpu_trace_ring_buffer_unit #(
   parameter int NUM_CPUS   = 4,
   parameter int RING_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cpu_id[1:0], tick_now[33:2], event_code[41:34], task_num[49:42],
   // payload[65:50], read_index[81:66], zero[87:82]
   input  logic [pctrb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type[1:0]
   input  logic [pctrb_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_tick[31:0], out_event[39:32], out_task[47:40], out_data[63:48],
   // total_count[72:64], local_count[79:73]
   output logic [pctrb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found[0]
   output logic [pctrb_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   import pctrb_pkg::*;

   localparam int CPU_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int HEAD_W    = $clog2(RING_DEPTH);
   localparam int POS_W     = HEAD_W + 1;
   localparam int CNT_W     = $clog2(RING_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_CPUS * RING_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int TOT_W     = $clog2(MEM_DEPTH + 1);
   localparam int TOT_X     = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;
   localparam int CNT_X     = (CNT_W > LOCAL_W) ? CNT_W : LOCAL_W;

   function automatic logic [LOCAL_W-1:0] sat_local(input logic [CNT_W-1:0] v);
      logic [CNT_X-1:0] x;
      x = CNT_X'(v);
      return (x > CNT_X'(LOCAL_MAX)) ? LOCAL_W'(LOCAL_MAX) : x[LOCAL_W-1:0];
   endfunction

   // request fields
   req_kind_type      req_kind;
   logic [1:0]        cpu_raw;
   logic [4:0]        cpu_wide;
   logic [CPU_W-1:0]  cpu_sel;
   record_type        in_rec;
   logic [INDEX_W-1:0] in_index;

   assign req_kind          = req_kind_type'(req_tuser);
   assign cpu_raw           = req_tdata[1:0];
   assign in_rec.tick       = req_tdata[33:2];
   assign in_rec.event_code = req_tdata[41:34];
   assign in_rec.task_num   = req_tdata[49:42];
   assign in_rec.data       = req_tdata[65:50];
   assign in_index          = req_tdata[81:66];
   assign cpu_wide          = {3'b000, cpu_raw};
   // ids past the last CPU fold to CPU 0
   assign cpu_sel = (cpu_wide >= 5'(NUM_CPUS)) ? '0 : cpu_wide[CPU_W-1:0];

   // state
   state_type          state_ff, state_in;
   logic [HEAD_W-1:0]  head_ff  [NUM_CPUS];
   logic [HEAD_W-1:0]  head_in  [NUM_CPUS];
   logic [CNT_W-1:0]   count_ff [NUM_CPUS];
   logic [CNT_W-1:0]   count_in [NUM_CPUS];
   logic [NUM_CPUS-1:0] stale_ff, stale_in;
   logic [TOT_W-1:0]   total_ff, total_in;
   logic [CPU_W-1:0]   walk_ff, walk_in;
   logic [INDEX_W-1:0] rem_ff, rem_in;
   logic               hit_ff, hit_in;
   logic [LOCAL_W-1:0] local_ff, local_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   record_type         rsp_rec_ff, rsp_rec_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;
   logic [LOCAL_W-1:0] rsp_local_ff, rsp_local_in;

   // ring metadata lookup: requesting CPU on accept, walk pointer during a walk
   logic [CPU_W-1:0]   meta_idx;
   logic [HEAD_W-1:0]  m_head;
   logic [CNT_W-1:0]   m_count;
   logic               m_stale;
   logic [CNT_W-1:0]   m_live;
   logic [INDEX_W-1:0] offset;
   logic               off_ok;
   logic [HEAD_W-1:0]  oldest;
   logic [POS_W-1:0]   pos_sum;
   logic [POS_W-1:0]   pos_wrap;
   logic [ADDR_W-1:0]  ring_base;

   logic [HEAD_W-1:0]  base_head;
   logic [CNT_W-1:0]   base_count;
   logic               not_full;
   logic [HEAD_W-1:0]  new_head;
   logic [CNT_W-1:0]   new_count;

   logic               accept;
   logic               out_free;
   logic               walk_last;
   logic [TOT_X-1:0]   total_x;

   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [REC_W-1:0]   mem_rd_data;

   assign meta_idx = (state_ff == ST_WALK) ? walk_ff : cpu_sel;
   assign m_head   = head_ff[meta_idx];
   assign m_count  = count_ff[meta_idx];
   assign m_stale  = stale_ff[meta_idx];
   assign m_live   = m_stale ? '0 : m_count;

   assign offset   = (state_ff == ST_WALK) ? rem_ff : in_index;
   assign off_ok   = offset < INDEX_W'(m_live);
   // a full ring has its oldest entry at the head
   assign oldest   = (m_count < CNT_W'(RING_DEPTH)) ? '0 : m_head;
   assign pos_sum  = {1'b0, oldest} + {1'b0, offset[HEAD_W-1:0]};
   assign pos_wrap = (pos_sum >= POS_W'(RING_DEPTH)) ? pos_sum - POS_W'(RING_DEPTH)
                                                     : pos_sum;
   assign ring_base = ADDR_W'(meta_idx) * ADDR_W'(RING_DEPTH);

   // a stale ring restarts empty on its next record
   assign base_head  = m_stale ? '0 : m_head;
   assign base_count = m_stale ? '0 : m_count;
   assign not_full   = base_count < CNT_W'(RING_DEPTH);
   assign new_head   = (base_head == HEAD_W'(RING_DEPTH - 1)) ? '0 : base_head + 1'b1;
   assign new_count  = not_full ? base_count + 1'b1 : base_count;

   assign mem_wr_addr = ring_base + ADDR_W'(base_head);
   assign mem_rd_addr = ring_base + ADDR_W'(pos_wrap[HEAD_W-1:0]);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign walk_last  = (walk_ff == CPU_W'(NUM_CPUS - 1));
   assign total_x    = TOT_X'(total_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_kind == REQ_READ_ALL) ? ST_WALK : ST_FINISH;
            end
         end
         ST_WALK: begin
            if (off_ok || walk_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ring updates, walk and result register
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      stale_in     = stale_ff;
      total_in     = total_ff;
      walk_in      = walk_ff;
      rem_in       = rem_ff;
      hit_in       = hit_ff;
      local_in     = local_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_found_in = rsp_found_ff;
      rsp_rec_in   = rsp_rec_ff;
      rsp_total_in = rsp_total_ff;
      rsp_local_in = rsp_local_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               walk_in  = '0;
               rem_in   = in_index;
               hit_in   = 1'b0;
               local_in = sat_local(m_live);
               unique case (req_kind)
                  REQ_RECORD: begin
                     mem_wr_en         = 1'b1;
                     head_in[cpu_sel]  = new_head;
                     count_in[cpu_sel] = new_count;
                     stale_in[cpu_sel] = 1'b0;
                     total_in          = total_ff + TOT_W'(not_full);
                     local_in          = sat_local(new_count);
                  end
                  REQ_READ_ALL: begin
                  end
                  REQ_READ_LOCAL: begin
                     if (off_ok) begin
                        mem_rd_en = 1'b1;
                        hit_in    = 1'b1;
                     end
                  end
                  REQ_CLEAR: begin
                     stale_in          = '1;
                     stale_in[cpu_sel] = 1'b0;
                     head_in[cpu_sel]  = '0;
                     count_in[cpu_sel] = '0;
                     total_in          = '0;
                     local_in          = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (off_ok) begin
               mem_rd_en = 1'b1;
               hit_in    = 1'b1;
            end else if (!walk_last) begin
               rem_in  = rem_ff - INDEX_W'(m_live);
               walk_in = walk_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_rec_in   = hit_ff ? record_type'(mem_rd_data) : '0;
               rsp_total_in = (total_x > TOT_X'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                            : total_x[TOTAL_W-1:0];
               rsp_local_in = local_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stale_ff     <= '1;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CPUS; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         stale_ff     <= stale_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff      <= walk_in;
      rem_ff       <= rem_in;
      hit_ff       <= hit_in;
      local_ff     <= local_in;
      rsp_found_ff <= rsp_found_in;
      rsp_rec_ff   <= rsp_rec_in;
      rsp_total_ff <= rsp_total_in;
      rsp_local_ff <= rsp_local_in;
   end

   pctrb_ram #(
      .WIDTH (REC_W),
      .DEPTH (MEM_DEPTH)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (in_rec),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_local_ff, rsp_total_ff, rsp_rec_ff.data, rsp_rec_ff.task_num,
                        rsp_rec_ff.event_code, rsp_rec_ff.tick};
   assign rsp_tuser  = rsp_found_ff;

endmodule

/* rtl/pctrb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pctrb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* tb/trace_ring_checker.sv */
// Checker for the per-CPU trace ring buffer: models the rings and scores rsp words.
module trace_ring_checker #(
   parameter int NUM_CPUS   = 4,
   parameter int RING_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // cpu_id[1:0], tick_now[33:2], event_code[41:34], task_num[49:42],
   // payload[65:50], read_index[81:66], zero[87:82]
   input  logic [pctrb_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  logic [pctrb_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_tick[31:0], out_event[39:32], out_task[47:40], out_data[63:48],
   // total_count[72:64], local_count[79:73]
   input  logic [pctrb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // found[0]
   input  logic [pctrb_pkg::RSP_USER_W-1:0] rsp_tuser,
   output int                               fail_count,
   output int                               outstanding
);
   import pctrb_pkg::*;

   localparam int POS_W  = $clog2(RING_DEPTH);
   localparam int FILL_W = $clog2(RING_DEPTH + 1);

   typedef struct packed {
      logic               found;
      logic [31:0]        tick;
      logic [7:0]         event_code;
      logic [7:0]         task_num;
      logic [15:0]        data;
      logic [TOTAL_W-1:0] total_cnt;
      logic [LOCAL_W-1:0] local_cnt;
   } trace_reply_type;

   record_type         ring_mem [NUM_CPUS][RING_DEPTH];
   logic [POS_W-1:0]   wr_ptr   [NUM_CPUS];
   logic [FILL_W-1:0]  fill_cnt [NUM_CPUS];
   logic               is_stale [NUM_CPUS];
   trace_reply_type    expected_replies [$];
   int                 mismatches = 0;

   assign fail_count = mismatches;

   // a stale ring reads as empty
   function automatic int unsigned live_fill(int c);
      return is_stale[c] ? 0 : int'(fill_cnt[c]);
   endfunction

   function automatic record_type ring_entry(int c, int unsigned n);
      int unsigned first;
      first = (fill_cnt[c] < RING_DEPTH) ? 0 : int'(wr_ptr[c]);
      return ring_mem[c][(first + n) % RING_DEPTH];
   endfunction

   function automatic trace_reply_type predict_trace_reply(req_kind_type kind, int cpu,
                                                           record_type rec_in,
                                                           int unsigned idx);
      trace_reply_type r;
      int unsigned     sum;
      int unsigned     lv;
      r = '0;
      if (cpu >= NUM_CPUS) cpu = 0;
      case (kind)
         REQ_RECORD: begin
            if (is_stale[cpu]) begin
               wr_ptr[cpu]   = '0;
               fill_cnt[cpu] = '0;
               is_stale[cpu] = 1'b0;
            end
            ring_mem[cpu][wr_ptr[cpu]] = rec_in;
            wr_ptr[cpu] = POS_W'((int'(wr_ptr[cpu]) + 1) % RING_DEPTH);
            if (fill_cnt[cpu] < RING_DEPTH) fill_cnt[cpu] = fill_cnt[cpu] + 1'b1;
         end
         REQ_READ_ALL: begin
            // walk the live rings in CPU order
            for (int c = 0; c < NUM_CPUS; c++) begin
               if (!r.found) begin
                  lv = live_fill(c);
                  if (idx >= lv) begin
                     idx -= lv;
                  end else begin
                     r.found = 1'b1;
                     {r.tick, r.event_code, r.task_num, r.data} = ring_entry(c, idx);
                  end
               end
            end
         end
         REQ_READ_LOCAL: begin
            if (idx < live_fill(cpu)) begin
               r.found = 1'b1;
               {r.tick, r.event_code, r.task_num, r.data} = ring_entry(cpu, idx);
            end
         end
         REQ_CLEAR: begin
            for (int c = 0; c < NUM_CPUS; c++) is_stale[c] = 1'b1;
            wr_ptr[cpu]   = '0;
            fill_cnt[cpu] = '0;
            is_stale[cpu] = 1'b0;
         end
      endcase
      sum = 0;
      for (int c = 0; c < NUM_CPUS; c++) sum += live_fill(c);
      r.total_cnt = (sum > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(sum);
      lv = live_fill(cpu);
      r.local_cnt = (lv > LOCAL_MAX) ? LOCAL_W'(LOCAL_MAX) : LOCAL_W'(lv);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : score
      trace_reply_type want;
      trace_reply_type got;
      record_type      rec_in;
      if (reset) begin
         for (int c = 0; c < NUM_CPUS; c++) begin
            wr_ptr[c]   = '0;
            fill_cnt[c] = '0;
            is_stale[c] = 1'b1;
         end
         expected_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found      = rsp_tuser[0];
            got.tick       = rsp_tdata[31:0];
            got.event_code = rsp_tdata[39:32];
            got.task_num   = rsp_tdata[47:40];
            got.data       = rsp_tdata[63:48];
            got.total_cnt  = rsp_tdata[72:64];
            got.local_cnt  = rsp_tdata[79:73];
            if (expected_replies.size() == 0) begin
               $error("rsp word with no request waiting");
               mismatches++;
            end else begin
               want = expected_replies.pop_front();
               check_field("found", 32'(want.found), 32'(got.found));
               check_field("out_tick", want.tick, got.tick);
               check_field("out_event", 32'(want.event_code), 32'(got.event_code));
               check_field("out_task", 32'(want.task_num), 32'(got.task_num));
               check_field("out_data", 32'(want.data), 32'(got.data));
               check_field("total_count", 32'(want.total_cnt), 32'(got.total_cnt));
               check_field("local_count", 32'(want.local_cnt), 32'(got.local_cnt));
            end
         end
         if (req_tvalid && req_tready) begin
            rec_in.tick       = req_tdata[33:2];
            rec_in.event_code = req_tdata[41:34];
            rec_in.task_num   = req_tdata[49:42];
            rec_in.data       = req_tdata[65:50];
            expected_replies.push_back(predict_trace_reply(req_kind_type'(req_tuser),
                                                           int'(req_tdata[1:0]), rec_in,
                                                           int'(req_tdata[81:66])));
         end
      end
      outstanding <= expected_replies.size();
   end

endmodule

/* tb/tb_top.sv */
// Top of the trace ring buffer testbench: clock, reset, request traffic and verdict.
module tb_top;
   import pctrb_pkg::*;

   localparam int NUM_CPUS    = 4;
   localparam int RING_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 500000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   int          fail_count;
   int          outstanding;
   int          cycles = 0;
   bit          hold_off_req = 1'b0;
   bit          hold_off_taken = 1'b0;
   int          stall_left = 0;
   int          calm_left = 0;
   logic [31:0] tick_base = 32'd100;

   per_cpu_trace_ring_buffer_unit #(
      .NUM_CPUS   (NUM_CPUS),
      .RING_DEPTH (RING_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   trace_ring_checker #(
      .NUM_CPUS   (NUM_CPUS),
      .RING_DEPTH (RING_DEPTH)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side: short stalls, rare long ones, calm stretches, one long hold-off
   always @(posedge clock) begin : rsp_side
      int roll;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_off_req && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            stall_left     = 300;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else begin
               roll = $urandom_range(99, 0);
               if (roll < 5) begin
                  calm_left = $urandom_range(200, 50);
               end else if (roll < 10) begin
                  stall_left = $urandom_range(40, 10);
               end else if (roll < 40) begin
                  stall_left = $urandom_range(3, 1);
               end
            end
         end
      end
   end

   // drives one word and returns at the edge where it is taken
   task automatic offer_word(input req_kind_type kind, input logic [1:0] cpu,
                             input logic [31:0] tick, input logic [7:0] ev,
                             input logic [7:0] tk, input logic [15:0] data,
                             input logic [15:0] idx);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {6'b0, idx, data, tk, ev, tick, cpu};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic sender_pause(input bit calm);
      int pick;
      pick = $urandom_range(99, 0);
      if (calm || pick < 50) return;
      req_tvalid <= 1'b0;
      if (pick < 92) repeat ($urandom_range(3, 1)) @(posedge clock);
      else repeat ($urandom_range(40, 8)) @(posedge clock);
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic random_word(input int hot, input int clear_pct, input int rec_pct);
      int           pick;
      req_kind_type kind;
      logic [1:0]   cpu;
      logic [31:0]  tick;
      logic [15:0]  idx;
      pick = $urandom_range(99, 0);
      if (pick < clear_pct) kind = REQ_CLEAR;
      else if (pick < clear_pct + rec_pct) kind = REQ_RECORD;
      else if (pick[0]) kind = REQ_READ_ALL;
      else kind = REQ_READ_LOCAL;
      // bias toward one CPU so its ring wraps
      cpu = ($urandom_range(99, 0) < 60) ? 2'(hot) : 2'($urandom_range(3, 0));
      tick_base = tick_base + $urandom_range(20, 1);
      tick = ($urandom_range(3, 0) == 0) ? $urandom : tick_base;
      case ($urandom_range(9, 0))
         0, 1, 2, 3: idx = 16'($urandom_range(15, 0));
         4, 5, 6, 7, 8: idx = 16'($urandom_range(270, 0));
         default: idx = 16'($urandom);
      endcase
      offer_word(kind, cpu, tick, 8'($urandom), 8'($urandom), 16'($urandom), idx);
   endtask

   initial begin : stimulus
      int hot;
      int clear_pct;
      int rec_pct;
      bit calm;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty and stale rings, clear on a stale ring, field extremes
      offer_word(REQ_READ_ALL,   2'd0, '0, '0, '0, '0, 16'd0);
      offer_word(REQ_READ_LOCAL, 2'd3, '0, '0, '0, '0, 16'd0);
      offer_word(REQ_CLEAR,      2'd2, '0, '0, '0, '0, 16'd0);
      offer_word(REQ_RECORD,     2'd0, 32'd0, 8'd0, 8'd0, 16'd0, 16'd0);
      offer_word(REQ_RECORD,     2'd0, '1, '1, '1, '1, '1);
      offer_word(REQ_RECORD,     2'd1, 32'hA5A5_5A5A, 8'h5A, 8'hA5, 16'h5AA5, 16'hA5A5);
      offer_word(REQ_RECORD,     2'd3, 32'h1234_5678, 8'h81, 8'h7E, 16'hC33C, 16'h5A5A);
      offer_word(REQ_READ_LOCAL, 2'd0, '0, '0, '0, '0, 16'd1);
      offer_word(REQ_READ_LOCAL, 2'd0, '0, '0, '0, '0, 16'd2);
      offer_word(REQ_READ_ALL,   2'd2, '0, '0, '0, '0, 16'd2);
      offer_word(REQ_READ_ALL,   2'd1, '0, '0, '0, '0, 16'd3);
      offer_word(REQ_READ_ALL,   2'd3, '0, '0, '0, '0, 16'd4);
      offer_word(REQ_READ_ALL,   2'd0, '0, '0, '0, '0, 16'hFFFF);
      offer_word(REQ_READ_LOCAL, 2'd1, '0, '0, '0, '0, 16'hFFFF);
      offer_word(REQ_CLEAR,      2'd1, '0, '0, '0, '0, 16'd0);
      offer_word(REQ_READ_ALL,   2'd1, '0, '0, '0, '0, 16'd0);
      offer_word(REQ_RECORD,     2'd0, 32'hDEAD_0001, 8'h11, 8'h22, 16'h3344, 16'd0);
      offer_word(REQ_READ_LOCAL, 2'd0, '0, '0, '0, '0, 16'd0);
      offer_word(REQ_READ_ALL,   2'd3, '0, '0, '0, '0, 16'd0);
      wait_for_replies();

      for (int round = 0; round < 7; round++) begin
         hot       = $urandom_range(3, 0);
         clear_pct = (round % 3 == 0) ? 0 : ((round % 3 == 1) ? 2 : 6);
         rec_pct   = (round % 3 == 0) ? 85 : 50;
         calm      = ($urandom_range(2, 0) == 0);
         if (round == 2) hold_off_req = 1'b1;
         for (int n = 0; n < 150; n++) begin
            random_word(hot, clear_pct, rec_pct);
            sender_pause(calm);
         end
         if (round == 1 || round == 4) wait_for_replies();
      end

      wait_for_replies();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
